// ----- hdl/gdfc_pkg.sv -----
`default_nettype none

package gdfc_pkg;

    // Default geometry of the value path
    localparam int VALUE_WIDTH_DEF = 48;
    localparam int FRAC_BITS_DEF   = 20;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths of the item
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 24;
    localparam int FREQ_W  = 26;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_GPS     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SW      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // Filter coefficients, Q2.28, held as sign and magnitude
    localparam int COEF_FRAC  = 28;
    localparam int COEF_MAG_W = 29;
    localparam logic [COEF_MAG_W-1:0] COEF_A1_MAG   = 29'd512041056;
    localparam logic                  COEF_A1_NEG   = 1'b1;
    localparam logic [COEF_MAG_W-1:0] COEF_A2_MAG   = 29'd244704288;
    localparam logic [COEF_MAG_W-1:0] COEF_GAIN_MAG = 29'd274668;

    // Scaling of the phase difference
    localparam int                    SW_SCALE_W  = 20;
    localparam logic [COEF_MAG_W-1:0] SW_SCALE    = 29'd600000;
    localparam logic [FREQ_W-1:0]     GPS_DIVISOR = 26'd100;

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_TICK_W = 16;

    localparam logic [REG_IDX_W-1:0] REG_INIT_COEFF = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INIT_A     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_B     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WARMUP     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLD       = 3'd4;

    localparam logic [CFG_TICK_W-1:0] WARMUP_RESET = 16'd2;
    localparam logic [CFG_TICK_W-1:0] HOLD_RESET   = 16'd600;

endpackage

`default_nettype wire

// ----- hdl/gps_disciplined_freq_corrector.sv -----
// Frequency-correction loop for a GPS-disciplined clock. Each input item is a GPS tick, a
// software adjustment or a restart, and each yields one result item holding the coefficient,
// both filter delays and the warm-up flag after the item. Arithmetic runs through a bit-serial
// shift-add multiplier (one coefficient bit per cycle) and a bit-serial restoring divider
// (one quotient bit per cycle). A software adjustment takes one more multiply than a filtered
// GPS tick; warm-up ticks, unfiltered ticks and restarts skip the arithmetic. One item
// is worked on at a time; a finished result waits in the output register while the next
// item is accepted. Configuration sits on an APB port with 64-bit data, register i at byte
// address 8*i; the user must write it only while the block is idle, which the block
// itself does not enforce.
`default_nettype none

module gps_disciplined_freq_corrector #(
    parameter int VALUE_WIDTH = gdfc_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = gdfc_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = gdfc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [gdfc_pkg::MODE_W-1:0]         mode,
    input  wire logic signed [gdfc_pkg::PHASE_W-1:0] phase_diff,
    input  wire logic                                gps_valid,
    input  wire logic [gdfc_pkg::FREQ_W-1:0]         ref_freq_hz,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [VALUE_WIDTH-1:0]            coeff,
    output logic signed [VALUE_WIDTH-1:0]            filter_state_a,
    output logic signed [VALUE_WIDTH-1:0]            filter_state_b,
    output logic                                     warming_up,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gdfc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [gdfc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [gdfc_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    import gdfc_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int NUM_W = PHASE_W + SW_SCALE_W;
    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int MAG_W = VW + 2;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_MUL  = 13'b0000000000010,
        ST_MRND = 13'b0000000000100,
        ST_DIV  = 13'b0000000001000,
        ST_DRND = 13'b0000000010000,
        ST_T1   = 13'b0000000100000,
        ST_T2   = 13'b0000001000000,
        ST_P1   = 13'b0000010000000,
        ST_P2   = 13'b0000100000000,
        ST_P3   = 13'b0001000000000,
        ST_PG   = 13'b0010000000000,
        ST_ACC  = 13'b0100000000000,
        ST_DONE = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        SEL_SW,
        SEL_A1,
        SEL_A2,
        SEL_GAIN
    } mul_sel_t;

    // Saturate a magnitude to the signed range and apply the sign
    function automatic logic [VW-1:0] clamp_mag(input logic neg, input logic ovf,
                                                input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] lim;
        logic [VW-1:0]    m;
        lim = {2'b00, neg, {(VW-1){~neg}}};
        m   = (ovf || (mag > lim)) ? lim[VW-1:0] : mag[VW-1:0];
        return neg ? (~m + VW'(1)) : m;
    endfunction

    function automatic logic [VW-1:0] abs_val(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + VW'(1)) : v;
    endfunction

    state_t                  state_reg, state_next;
    mul_sel_t                mul_sel_reg;

    logic [VW-1:0]           coeff_reg, delay_a_reg, delay_b_reg;
    logic                    warm_flag_reg, prev_valid_reg;
    logic [COUNT_WIDTH-1:0]  warm_count_reg;
    logic                    out_valid_reg;

    logic [VW-1:0]           init_coeff_reg, init_a_reg, init_b_reg;
    logic [CFG_TICK_W-1:0]   warmup_reg, hold_reg;

    logic [VW-1:0]           x_reg, m_reg;
    logic [VW-1:0]           mcand_reg, acc_hi_reg;
    logic [COEF_MAG_W-1:0]   mplier_reg, acc_lo_reg;
    logic                    mneg_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [FREQ_W-1:0]       rem_reg, f_reg;
    logic [VW-1:0]           q_reg;
    logic                    ovf_reg, neg_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [VW-1:0]           out_coeff_reg, out_a_reg, out_b_reg;
    logic                    out_warm_reg;

    logic                    in_fire, out_free, cfg_wr;
    logic [REG_IDX_W-1:0]    cfg_idx;
    logic [PHASE_W-1:0]      pd_mag;
    logic                    mul_last, div_last;
    logic [VW:0]             mul_sum;
    logic [VW+COEF_MAG_W-1:0] prod_full;
    logic [MAG_W-1:0]        mul_mag, div_mag;
    logic [FREQ_W:0]         rem_sh, rem_diff;
    logic                    div_ge, div_rnd;
    logic [VW-1:0]           add_a, add_b, add_res;
    logic                    add_sub;
    logic [VW:0]             add_s;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[CFG_ADDR_W-1:3];
    assign pready   = 1'b1;

    assign out_valid      = out_valid_reg;
    assign coeff          = out_coeff_reg;
    assign filter_state_a = out_a_reg;
    assign filter_state_b = out_b_reg;
    assign warming_up     = out_warm_reg;

    // Magnitude of the incoming phase difference
    assign pd_mag = phase_diff[PHASE_W-1] ? (~phase_diff + PHASE_W'(1)) : phase_diff;

    // Multiplier step and rounded result
    assign mul_last  = (cnt_reg == CNT_W'(COEF_MAG_W - 1));
    assign mul_sum   = {1'b0, acc_hi_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
    assign prod_full = {acc_hi_reg, acc_lo_reg};
    assign mul_mag   = MAG_W'({acc_hi_reg, acc_lo_reg[COEF_MAG_W-1:COEF_FRAC]})
                       + MAG_W'(acc_lo_reg[COEF_FRAC-1]);

    // Divider step and rounded result
    assign div_last = (cnt_reg == CNT_W'(DVD_W - 1));
    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, f_reg};
    assign div_ge   = (rem_sh >= {1'b0, f_reg});
    assign div_rnd  = (rem_reg >= (f_reg - (f_reg >> 1)));
    assign div_mag  = MAG_W'(q_reg) + MAG_W'(div_rnd);

    // Shared saturating adder
    always_comb
    begin
        add_a   = x_reg;
        add_b   = m_reg;
        add_sub = 1'b0;
        case (state_reg) inside
            ST_T1, ST_T2:
            begin
                add_sub = 1'b1;
            end
            ST_P1:
            begin
                add_a = delay_a_reg;
                add_b = delay_a_reg;
            end
            ST_P3:
            begin
                add_a = m_reg;
                add_b = delay_b_reg;
            end
            ST_ACC:
            begin
                add_a = coeff_reg;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_s = add_sub ? ({add_a[VW-1], add_a} - {add_b[VW-1], add_b})
                        : ({add_a[VW-1], add_a} + {add_b[VW-1], add_b});
        if (add_s[VW] != add_s[VW-1])
        begin
            add_res = {add_s[VW], {(VW-1){~add_s[VW]}}};
        end
        else
        begin
            add_res = add_s[VW-1:0];
        end
    end

    // Sequence the item through scaling, filter and accumulation
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (mode)
                        MODE_GPS:
                        begin
                            if (!warm_flag_reg && gps_valid && prev_valid_reg)
                            begin
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        MODE_SW:
                        begin
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ST_MRND;
                end
            end
            ST_MRND:
            begin
                case (mul_sel_reg)
                    SEL_SW:   state_next = ST_DIV;
                    SEL_A1:   state_next = ST_T1;
                    SEL_A2:   state_next = ST_T2;
                    default:  state_next = ST_ACC;
                endcase
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_DRND;
                end
            end
            ST_DRND:  state_next = ST_MUL;
            ST_T1:    state_next = ST_MUL;
            ST_T2:    state_next = ST_P1;
            ST_P1:    state_next = ST_P2;
            ST_P2:    state_next = ST_P3;
            ST_P3:    state_next = ST_PG;
            ST_PG:    state_next = ST_MUL;
            ST_ACC:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Hold control state, loop state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mul_sel_reg    <= SEL_SW;
            coeff_reg      <= '0;
            delay_a_reg    <= '0;
            delay_b_reg    <= '0;
            warm_flag_reg  <= 1'b1;
            warm_count_reg <= COUNT_WIDTH'(2);
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            init_coeff_reg <= '0;
            init_a_reg     <= '0;
            init_b_reg     <= '0;
            warmup_reg     <= WARMUP_RESET;
            hold_reg       <= HOLD_RESET;
        end
        else
        begin
            state_reg <= state_next;

            // Take configuration writes
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_INIT_COEFF: init_coeff_reg <= pwdata[VW-1:0];
                    REG_INIT_A:     init_a_reg     <= pwdata[VW-1:0];
                    REG_INIT_B:     init_b_reg     <= pwdata[VW-1:0];
                    REG_WARMUP:     warmup_reg     <= pwdata[CFG_TICK_W-1:0];
                    REG_HOLD:       hold_reg       <= pwdata[CFG_TICK_W-1:0];
                    default:        ;
                endcase
            end

            // Decode the accepted item
            if (in_fire)
            begin
                case (mode)
                    MODE_GPS:
                    begin
                        prev_valid_reg <= gps_valid;
                        if (warm_flag_reg)
                        begin
                            if (warm_count_reg == '0)
                            begin
                                warm_flag_reg <= 1'b0;
                            end
                            else
                            begin
                                warm_count_reg <= warm_count_reg - COUNT_WIDTH'(1);
                            end
                        end
                    end
                    MODE_SW:
                    begin
                        warm_flag_reg  <= 1'b1;
                        warm_count_reg <= COUNT_WIDTH'(hold_reg);
                        mul_sel_reg    <= SEL_SW;
                    end
                    MODE_RESTART:
                    begin
                        coeff_reg      <= init_coeff_reg;
                        delay_a_reg    <= init_a_reg;
                        delay_b_reg    <= init_b_reg;
                        warm_flag_reg  <= 1'b1;
                        warm_count_reg <= COUNT_WIDTH'(warmup_reg);
                    end
                    default:
                    begin
                        prev_valid_reg <= prev_valid_reg;
                    end
                endcase
            end

            // Pick the next product and advance the filter
            if (state_reg == ST_DRND)
            begin
                mul_sel_reg <= SEL_A1;
            end
            if (state_reg == ST_T1)
            begin
                mul_sel_reg <= SEL_A2;
            end
            if (state_reg == ST_PG)
            begin
                mul_sel_reg <= SEL_GAIN;
            end
            if (state_reg == ST_P3)
            begin
                delay_b_reg <= delay_a_reg;
                delay_a_reg <= x_reg;
            end
            if (state_reg == ST_ACC)
            begin
                coeff_reg <= add_res;
            end

            // Present and release the result item
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Serial multiplier, divider and working values
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_reg    <= phase_diff[PHASE_W-1];
                    cnt_reg    <= '0;
                    mcand_reg  <= VW'(pd_mag);
                    mplier_reg <= SW_SCALE;
                    acc_hi_reg <= '0;
                    dvd_reg    <= {NUM_W'(pd_mag), {FRAC_BITS{1'b0}}};
                    rem_reg    <= '0;
                    q_reg      <= '0;
                    ovf_reg    <= 1'b0;
                    if (mode == MODE_SW)
                    begin
                        f_reg <= (ref_freq_hz == '0) ? FREQ_W'(1) : ref_freq_hz;
                    end
                    else
                    begin
                        f_reg <= GPS_DIVISOR;
                    end
                end
            end
            ST_MUL:
            begin
                acc_hi_reg <= mul_sum[VW:1];
                acc_lo_reg <= {mul_sum[0], acc_lo_reg[COEF_MAG_W-1:1]};
                mplier_reg <= {1'b0, mplier_reg[COEF_MAG_W-1:1]};
                cnt_reg    <= cnt_reg + CNT_W'(1);
            end
            ST_MRND:
            begin
                if (mul_sel_reg == SEL_SW)
                begin
                    dvd_reg <= {prod_full[NUM_W-1:0], {FRAC_BITS{1'b0}}};
                    rem_reg <= '0;
                    q_reg   <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= '0;
                end
                else
                begin
                    m_reg <= clamp_mag(mneg_reg, 1'b0, mul_mag);
                end
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? rem_diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
                q_reg   <= {q_reg[VW-2:0], div_ge};
                ovf_reg <= ovf_reg | q_reg[VW-1];
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_DRND:
            begin
                x_reg      <= clamp_mag(neg_reg, ovf_reg, div_mag);
                mcand_reg  <= abs_val(delay_a_reg);
                mplier_reg <= COEF_A1_MAG;
                mneg_reg   <= delay_a_reg[VW-1] ^ COEF_A1_NEG;
                acc_hi_reg <= '0;
                cnt_reg    <= '0;
            end
            ST_T1:
            begin
                x_reg      <= add_res;
                mcand_reg  <= abs_val(delay_b_reg);
                mplier_reg <= COEF_A2_MAG;
                mneg_reg   <= delay_b_reg[VW-1];
                acc_hi_reg <= '0;
                cnt_reg    <= '0;
            end
            ST_T2:
            begin
                x_reg <= add_res;
            end
            ST_P1, ST_P2, ST_P3:
            begin
                m_reg <= add_res;
            end
            ST_PG:
            begin
                mcand_reg  <= abs_val(m_reg);
                mplier_reg <= COEF_GAIN_MAG;
                mneg_reg   <= m_reg[VW-1];
                acc_hi_reg <= '0;
                cnt_reg    <= '0;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_coeff_reg <= coeff_reg;
                    out_a_reg     <= delay_a_reg;
                    out_b_reg     <= delay_b_reg;
                    out_warm_reg  <= warm_flag_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Return register contents
    always_comb
    begin
        unique case (cfg_idx)
            REG_INIT_COEFF: prdata = CFG_DATA_W'(init_coeff_reg);
            REG_INIT_A:     prdata = CFG_DATA_W'(init_a_reg);
            REG_INIT_B:     prdata = CFG_DATA_W'(init_b_reg);
            REG_WARMUP:     prdata = CFG_DATA_W'(warmup_reg);
            REG_HOLD:       prdata = CFG_DATA_W'(hold_reg);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- bench/gdfc_loop_checker.sv -----
`timescale 1ns / 1ps

module gdfc_loop_checker #(
    parameter int VW = gdfc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic [gdfc_pkg::MODE_W-1:0]         mode,
    input  wire logic signed [gdfc_pkg::PHASE_W-1:0] phase_diff,
    input  wire logic                                gps_valid,
    input  wire logic [gdfc_pkg::FREQ_W-1:0]         ref_freq_hz,

    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [VW-1:0]                coeff,
    input  wire logic signed [VW-1:0]                filter_state_a,
    input  wire logic signed [VW-1:0]                filter_state_b,
    input  wire logic                                warming_up,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic                                pready,
    input  wire logic [gdfc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [gdfc_pkg::CFG_DATA_W-1:0]     pwdata,

    output int                                       pending_states,
    output int                                       fault_total
);
    import gdfc_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int CW = COUNT_WIDTH_DEF;

    localparam longint VAL_MAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam logic [127:0] POS_LIM = 128'(VAL_MAX);
    localparam logic [127:0] NEG_LIM = 128'(VAL_MAX) + 128'd1;

    // Filter taps as signed Q2.28 numbers
    localparam longint TAP_A1 = COEF_A1_NEG ? -longint'(COEF_A1_MAG) : longint'(COEF_A1_MAG);
    localparam longint TAP_A2 = longint'(COEF_A2_MAG);
    localparam longint TAP_GAIN = longint'(COEF_GAIN_MAG);

    typedef struct packed {
        logic [VW-1:0] coeff;
        logic [VW-1:0] state_a;
        logic [VW-1:0] state_b;
        logic          warm;
    } loop_state_t;

    // States still owed by the block, oldest first
    loop_state_t due_states_q[$];

    // Shadow of the restart and hold-off registers
    longint          load_coeff;
    longint          load_a;
    longint          load_b;
    logic [15:0]     load_warmup;
    logic [15:0]     load_hold;

    // Shadow of the loop state
    longint          acc;
    longint          dly_a;
    longint          dly_b;
    bit              warm;
    logic [CW-1:0]   warm_left;
    bit              last_mark_ok;

    int              fault_count = 0;
    int              results_seen = 0;

    task automatic note_fault(input string msg);
        $display("checker: %0t: %s", $realtime, msg);
        fault_count++;
    endtask

    function automatic longint clamp_mag(input bit neg, input logic [127:0] mag);
        logic [127:0] lim;
        logic [127:0] m;
        lim = neg ? NEG_LIM : POS_LIM;
        m = (mag > lim) ? lim : mag;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [127:0] mag128(input longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    // Round num * 2^FB / den to nearest, ties away from zero
    function automatic longint scale_q(input bit neg, input logic [127:0] num,
                                       input logic [127:0] den);
        return clamp_mag(neg, ((num << FB) + (den >> 1)) / den);
    endfunction

    // Product with a Q2.28 tap, rounded the same way
    function automatic longint mul_q28(input longint v, input longint c);
        logic [127:0] prod;
        prod = mag128(v) * mag128(c);
        return clamp_mag((v < 0) != (c < 0),
                         (prod + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC);
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > VAL_MAX)
            return VAL_MAX;
        if (s < VAL_MIN)
            return VAL_MIN;
        return s;
    endfunction

    // One pass through the biquad, output added to the coefficient
    task automatic run_biquad(input longint x);
        longint t;
        longint p;
        t = add_sat(x, -mul_q28(dly_a, TAP_A1));
        t = add_sat(t, -mul_q28(dly_b, TAP_A2));
        p = add_sat(add_sat(t, add_sat(dly_a, dly_a)), dly_b);
        dly_b = dly_a;
        dly_a = t;
        acc = add_sat(acc, mul_q28(p, TAP_GAIN));
    endtask

    task automatic step_correction(input logic [MODE_W-1:0] m,
                                   input logic signed [PHASE_W-1:0] diff,
                                   input logic valid, input logic [FREQ_W-1:0] freq);
        longint       d;
        bit           neg;
        logic [127:0] md;
        logic [127:0] f;
        loop_state_t  s;
        d = longint'(diff);
        neg = (d < 0);
        md = mag128(d);
        case (m)
            MODE_GPS:
            begin
                // warm-up only counts down, even on the tick that ends it
                if (warm)
                begin
                    if (warm_left == '0)
                        warm = 1'b0;
                    else
                        warm_left = warm_left - CW'(1);
                end
                else if (valid && last_mark_ok)
                begin
                    run_biquad(scale_q(neg, md, 128'(GPS_DIVISOR)));
                end
                last_mark_ok = valid;
            end
            MODE_SW:
            begin
                f = (freq == '0) ? 128'd1 : 128'(freq);
                warm = 1'b1;
                warm_left = load_hold;
                run_biquad(scale_q(neg, md * 128'(SW_SCALE), f));
            end
            MODE_RESTART:
            begin
                acc = load_coeff;
                dly_a = load_a;
                dly_b = load_b;
                warm = 1'b1;
                warm_left = load_warmup;
            end
            default:
            begin
                // spare code: state untouched
            end
        endcase
        s.coeff = acc[VW-1:0];
        s.state_a = dly_a[VW-1:0];
        s.state_b = dly_b[VW-1:0];
        s.warm = warm;
        due_states_q.push_back(s);
    endtask

    task automatic take_reg(input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
        logic [REG_IDX_W-1:0] idx;
        idx = addr[CFG_ADDR_W-1:3];
        case (idx)
            REG_INIT_COEFF: load_coeff = longint'($signed(data[VW-1:0]));
            REG_INIT_A:     load_a = longint'($signed(data[VW-1:0]));
            REG_INIT_B:     load_b = longint'($signed(data[VW-1:0]));
            REG_WARMUP:     load_warmup = data[15:0];
            REG_HOLD:       load_hold = data[15:0];
            default:        ;
        endcase
    endtask

    task automatic check_result();
        loop_state_t s;
        results_seen++;
        if (due_states_q.size() == 0)
        begin
            note_fault($sformatf("result %0d arrived with nothing pending", results_seen));
            return;
        end
        s = due_states_q.pop_front();
        if (coeff !== s.coeff)
            note_fault($sformatf("result %0d: coeff %h, want %h",
                                 results_seen, coeff, s.coeff));
        if (filter_state_a !== s.state_a)
            note_fault($sformatf("result %0d: filter_state_a %h, want %h",
                                 results_seen, filter_state_a, s.state_a));
        if (filter_state_b !== s.state_b)
            note_fault($sformatf("result %0d: filter_state_b %h, want %h",
                                 results_seen, filter_state_b, s.state_b));
        if (warming_up !== s.warm)
            note_fault($sformatf("result %0d: warming_up %b, want %b",
                                 results_seen, warming_up, s.warm));
    endtask

    // Follow register writes, accepted items and returned results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_coeff = 0;
            load_a = 0;
            load_b = 0;
            load_warmup = WARMUP_RESET;
            load_hold = HOLD_RESET;
            acc = 0;
            dly_a = 0;
            dly_b = 0;
            warm = 1'b1;
            warm_left = WARMUP_RESET;
            last_mark_ok = 1'b0;
            due_states_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                take_reg(paddr, pwdata);
            if (in_valid && in_ready)
                step_correction(mode, phase_diff, gps_valid, ref_freq_hz);
            if (out_valid && out_ready)
                check_result();
        end
        pending_states <= due_states_q.size();
        fault_total <= fault_count;
    end

endmodule

// ----- bench/tb_gps_disciplined_freq_corrector.sv -----
`timescale 1ns / 1ps

module tb_gps_disciplined_freq_corrector;
    import gdfc_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT = 4000;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [PHASE_W-1:0] DIFF_MAX = {1'b0, {(PHASE_W - 1){1'b1}}};
    localparam logic signed [PHASE_W-1:0] DIFF_MIN = {1'b1, {(PHASE_W - 1){1'b0}}};
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam longint VAL_MAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    logic                         clk;
    logic                         rst_n;

    logic                         in_valid;
    logic                         in_ready;
    logic [MODE_W-1:0]            mode;
    logic signed [PHASE_W-1:0]    phase_diff;
    logic                         gps_valid;
    logic [FREQ_W-1:0]            ref_freq_hz;

    logic                         out_valid;
    logic                         out_ready;
    logic signed [VW-1:0]         coeff;
    logic signed [VW-1:0]         filter_state_a;
    logic signed [VW-1:0]         filter_state_b;
    logic                         warming_up;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [CFG_ADDR_W-1:0]        paddr;
    logic [CFG_DATA_W-1:0]        pwdata;
    logic [CFG_DATA_W-1:0]        prdata;
    logic                         pready;

    int                           pending_states;
    int                           fault_total;
    int                           idle_cycles = 0;
    int                           tx_left = 0;
    bit                           tx_gaps = 1'b1;
    int                           rx_left = 0;
    bit                           rx_gaps = 1'b1;

    gps_disciplined_freq_corrector i_dut (.*);

    gdfc_loop_checker #(.VW(VW)) i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: stall at random after results, with stalls switched on or off for stretches of results
    initial
    begin
        int n;
        out_ready = 1'b1;
        forever
        begin
            do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
            if (rx_left == 0)
            begin
                rx_left = 64;
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            rx_left = rx_left - 1;
            n = rx_gaps ? $urandom_range(0, 16) : 0;
            if (n > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic [MODE_W-1:0] m, input logic signed [PHASE_W-1:0] d,
                             input logic v, input logic [FREQ_W-1:0] f);
        int gap;
        // switch gaps on or off for stretches of items
        if (tx_left == 0)
        begin
            tx_left = 48;
            tx_gaps = ($urandom_range(0, 3) != 0);
        end
        tx_left = tx_left - 1;
        gap = tx_gaps ? $urandom_range(0, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode <= m;
        phase_diff <= d;
        gps_valid <= v;
        ref_freq_hz <= f;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off until every result is back and the block has gone quiet
    task automatic drain_loop();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_states != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_regs(input longint c, input longint a, input longint b,
                             input int wu, input int hd);
        write_reg(REG_INIT_COEFF, 64'(c));
        write_reg(REG_INIT_A, 64'(a));
        write_reg(REG_INIT_B, 64'(b));
        write_reg(REG_WARMUP, 64'(wu));
        write_reg(REG_HOLD, 64'(hd));
    endtask

    function automatic longint rand_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return longint'($signed(raw[VW-1:0]));
    endfunction

    function automatic longint rand_delay();
        if ($urandom_range(0, 1) != 0)
            return rand_value();
        return longint'(int'($urandom) >>> 7);
    endfunction

    function automatic logic signed [PHASE_W-1:0] rand_diff();
        case ($urandom_range(0, 9))
            0:       return DIFF_MAX;
            1:       return DIFF_MIN;
            2, 3:    return PHASE_W'($urandom);
            default: return PHASE_W'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FREQ_MAX;
            2, 3:    return FREQ_W'($urandom_range(1, 100));
            4, 5:    return FREQ_W'($urandom);
            default: return FREQ_W'($urandom_range(1000000, 20000000));
        endcase
    endfunction

    // Mostly valid GPS marks so the filter runs, with adjusts, restarts and spare codes
    task automatic run_random(input int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
                push_item(MODE_GPS, rand_diff(), $urandom_range(0, 9) != 0, rand_freq());
            else if (r < 84)
                push_item(MODE_SW, rand_diff(), 1'($urandom_range(0, 1)), rand_freq());
            else if (r < 92)
                push_item(MODE_RESTART, rand_diff(), 1'($urandom_range(0, 1)), rand_freq());
            else
                push_item(MODE_SPARE, rand_diff(), 1'($urandom_range(0, 1)), rand_freq());
        end
    endtask

    task automatic run_directed();
        // warm-up from reset: count down, then the clearing tick
        push_item(MODE_GPS, '0, 1'b1, '0);
        push_item(MODE_GPS, DIFF_MAX, 1'b1, FREQ_MAX);
        push_item(MODE_GPS, DIFF_MIN, 1'b0, '0);
        // previous mark invalid: no filtering yet
        push_item(MODE_GPS, DIFF_MAX, 1'b1, '0);
        push_item(MODE_GPS, DIFF_MAX, 1'b1, '0);
        push_item(MODE_GPS, DIFF_MIN, 1'b1, FREQ_MAX);
        push_item(MODE_GPS, -24'sd1, 1'b1, '0);
        push_item(MODE_GPS, 24'sd50, 1'b1, 26'd1);
        push_item(MODE_SPARE, DIFF_MIN, 1'b1, FREQ_MAX);
        push_item(MODE_GPS, 24'sd1234, 1'b0, '0);
        // software adjusts: saturating scale, zero frequency, widest frequency
        push_item(MODE_SW, DIFF_MAX, 1'b0, 26'd1);
        push_item(MODE_SW, DIFF_MIN, 1'b1, '0);
        push_item(MODE_SW, -24'sd1, 1'b0, FREQ_MAX);
        push_item(MODE_GPS, DIFF_MAX, 1'b1, '0);
        push_item(MODE_RESTART, DIFF_MAX, 1'b1, FREQ_MAX);
        push_item(MODE_GPS, '0, 1'b1, '0);
        push_item(MODE_GPS, '0, 1'b1, '0);
        push_item(MODE_GPS, 24'sd777, 1'b1, '0);
        push_item(MODE_GPS, -24'sd9999, 1'b1, '0);
        push_item(MODE_GPS, 24'sd31415, 1'b1, '0);
        push_item(MODE_SPARE, '0, 1'b0, '0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_GPS;
        phase_diff = '0;
        gps_valid = 1'b0;
        ref_freq_hz = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register reset values first
        run_directed();
        drain_loop();

        load_regs(0, 0, 0, 0, 0);
        run_random(300);
        drain_loop();

        load_regs(VAL_MAX, VAL_MAX, VAL_MIN, 1, 65535);
        run_random(150);
        drain_loop();

        load_regs(VAL_MIN, VAL_MIN, VAL_MAX, 65535, 2);
        run_random(150);
        drain_loop();

        repeat (3)
        begin
            load_regs(rand_value(), rand_delay(), rand_delay(),
                      $urandom_range(0, 4), $urandom_range(0, 6));
            run_random(300);
            drain_loop();
        end

        if (fault_total == 0 && pending_states == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
